FILE: design/daily_event_schedule_table_macros.svh
// Assertion macros for the daily event schedule table.
// Included by the top level; no other dependencies.
`ifndef DAILY_EVENT_SCHEDULE_TABLE_MACROS_SVH
`define DAILY_EVENT_SCHEDULE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define DEST_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("schedule table assertion failed");

// Next-cycle implication, disabled during reset
`define DEST_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("schedule table assertion failed");

`else

`define DEST_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define DEST_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

FILE: design/dest_pkg.sv
// Shared types and constants for the daily event schedule table.
// No dependencies; imported by every module of the block.
`default_nettype none

package dest_pkg;

    localparam int ROOM_COUNT_DEF = 8;
    localparam int SLOTS_DEF      = 8;

    localparam int FUNCW  = 2;
    localparam int ROOMW  = 3;
    localparam int TW     = 17;
    localparam int SPW    = 8;
    localparam int HOURW  = 5;
    localparam int MINW   = 6;
    localparam int SECW   = 6;
    localparam int STATW  = 2;
    localparam int DW     = TW + 2;

    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int DAY_SECONDS  = 86400;

    typedef enum logic [FUNCW-1:0] {
        FUNC_ADD,
        FUNC_REMOVE,
        FUNC_QUERY,
        FUNC_NOP
    } func_t;

    typedef enum logic [STATW-1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_NOT_FOUND,
        STAT_EMPTY
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD,
        ST_RM_SCAN,
        ST_RM_RD,
        ST_RM_WR,
        ST_Q_MIN,
        ST_Q_SCAN,
        ST_Q_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        status_t               status;
        logic [ROOMW-1:0]      room;
        logic [TW-1:0]         ev_time;
        logic signed [SPW-1:0] setpoint;
        logic [TW-1:0]         wait_s;
    } result_t;

endpackage

`default_nettype wire

FILE: design/dest_store.sv
// Event storage: one time and setpoint per slot, one write and one read port.
// Read data is registered. Depends on dest_pkg.
`default_nettype none

module dest_store
    import dest_pkg::*;
#(
    parameter int  DEPTH = ROOM_COUNT_DEF * SLOTS_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [TW-1:0]         wtime,
    input  wire logic signed [SPW-1:0] wsp,
    input  wire logic [AW-1:0]         raddr,
    output logic [TW-1:0]              rtime,
    output logic signed [SPW-1:0]      rsp
);

    logic [TW-1:0]         time_mem [DEPTH];
    logic signed [SPW-1:0] sp_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            time_mem[waddr] <= wtime;
            sp_mem[waddr]   <= wsp;
        end
    end

    always_ff @(posedge clk)
    begin
        rtime <= time_mem[raddr];
        rsp   <= sp_mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/dest_seq.sv
// Sequencer and shared compare datapath: add, remove with gap close, query scan.
// Holds the per-room entry counts. Depends on dest_pkg; drives dest_store.
`default_nettype none

module dest_seq
    import dest_pkg::*;
#(
    parameter int  ROOM_COUNT     = ROOM_COUNT_DEF,
    parameter int  SLOTS_PER_ROOM = SLOTS_DEF,
    localparam int DEPTH          = ROOM_COUNT * SLOTS_PER_ROOM,
    localparam int AW             = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [FUNCW-1:0]      func,
    input  wire logic [ROOMW-1:0]      room,
    input  wire logic [TW-1:0]         event_time,
    input  wire logic signed [SPW-1:0] setpoint,
    input  wire logic [HOURW-1:0]      now_hour,
    input  wire logic [MINW-1:0]       now_minute,
    input  wire logic [SECW-1:0]       now_second,
    output logic                       busy,
    output logic                       res_valid,
    output result_t                    res,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [TW-1:0]              mem_wtime,
    output logic signed [SPW-1:0]      mem_wsp,
    output logic [AW-1:0]              mem_raddr,
    input  wire logic [TW-1:0]         mem_rtime,
    input  wire logic signed [SPW-1:0] mem_rsp
);

    localparam int RIW = (ROOM_COUNT > 1) ? $clog2(ROOM_COUNT) : 1;
    localparam int SIW = (SLOTS_PER_ROOM > 1) ? $clog2(SLOTS_PER_ROOM) : 1;
    localparam int CW  = $clog2(SLOTS_PER_ROOM + 1);
    localparam int RCW = $clog2(ROOM_COUNT + 1);

    localparam logic [CW-1:0]         SLOTS_C = CW'(SLOTS_PER_ROOM);
    localparam logic [RCW-1:0]        ROOMS_C = RCW'(ROOM_COUNT);
    localparam logic signed [DW-1:0]  DAY_C   = DW'(DAY_SECONDS);

    // control state
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg [ROOM_COUNT];
    logic [CW-1:0]    count_next [ROOM_COUNT];
    logic             pend_valid_reg, pend_valid_next;

    // payload
    func_t                 func_reg, func_next;
    logic [RIW-1:0]        rm_idx_reg, rm_idx_next;
    logic                  rm_ok_reg, rm_ok_next;
    logic [TW-1:0]         time_in_reg, time_in_next;
    logic signed [SPW-1:0] sp_in_reg, sp_in_next;
    logic [HOURW-1:0]      hour_reg, hour_next;
    logic [MINW-1:0]       min_reg, min_next;
    logic [SECW-1:0]       sec_reg, sec_next;
    logic [TW-1:0]         now_reg, now_next;
    logic [RCW-1:0]        room_reg, room_next;
    logic [CW-1:0]         slot_reg, slot_next;
    logic [SIW-1:0]        pend_slot_reg, pend_slot_next;
    logic [RIW-1:0]        pend_room_reg, pend_room_next;
    logic                  have_any_reg, have_any_next;
    logic                  have_later_reg, have_later_next;
    logic [TW-1:0]         early_time_reg, early_time_next;
    logic signed [SPW-1:0] early_sp_reg, early_sp_next;
    logic [RIW-1:0]        early_room_reg, early_room_next;
    logic [TW-1:0]         later_time_reg, later_time_next;
    logic signed [SPW-1:0] later_sp_reg, later_sp_next;
    logic [RIW-1:0]        later_room_reg, later_room_next;
    status_t               status_reg, status_next;
    logic [ROOMW-1:0]      res_room_reg, res_room_next;
    logic [TW-1:0]         res_time_reg, res_time_next;
    logic signed [SPW-1:0] res_sp_reg, res_sp_next;
    logic signed [DW-1:0]  diff_reg, diff_next;
    logic                  q_ok_reg, q_ok_next;

    // shared compare unit and helpers
    logic [CW-1:0]         rm_cnt;
    logic [CW-1:0]         scan_cnt;
    logic                  scan_live;
    logic                  rm_issue;
    logic                  scan_issue;
    logic [CW:0]           slot_p1;
    logic                  rm_last;
    logic                  hit;
    logic                  lt_early;
    logic                  gt_now;
    logic                  lt_later;
    logic                  cnt_we;
    logic [CW-1:0]         cnt_val;
    logic signed [DW-1:0]  diff_adj;
    logic [TW-1:0]         wait_val;

    function automatic logic [AW-1:0] ent_addr(input logic [RIW-1:0] r,
                                               input logic [SIW-1:0] s);
        return AW'(int'(r) * SLOTS_PER_ROOM + int'(s));
    endfunction

    assign rm_cnt     = count_reg[rm_idx_reg];
    assign scan_live  = room_reg < ROOMS_C;
    assign scan_cnt   = scan_live ? count_reg[room_reg[RIW-1:0]] : '0;
    assign rm_issue   = slot_reg < rm_cnt;
    assign scan_issue = slot_reg < scan_cnt;
    assign slot_p1    = (CW+1)'(slot_reg) + (CW+1)'(1);
    assign rm_last    = !(slot_p1 < (CW+1)'(rm_cnt));

    assign hit      = pend_valid_reg && (mem_rtime == time_in_reg) && (mem_rsp == sp_in_reg);
    assign lt_early = mem_rtime < early_time_reg;
    assign gt_now   = mem_rtime > now_reg;
    assign lt_later = mem_rtime < later_time_reg;

    // wrap the wait into one day; saturate at zero if still negative
    assign diff_adj = diff_reg + DAY_C;
    always_comb
    begin
        if (diff_reg > 0)
            wait_val = diff_reg[TW-1:0];
        else if (diff_adj < 0)
            wait_val = '0;
        else
            wait_val = diff_adj[TW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                case (func_reg)
                    FUNC_ADD:
                        state_next = (!rm_ok_reg || rm_cnt == SLOTS_C) ? ST_DONE : ST_ADD;
                    FUNC_REMOVE:
                        state_next = (!rm_ok_reg || rm_cnt == '0) ? ST_DONE : ST_RM_SCAN;
                    FUNC_QUERY:
                        state_next = ST_Q_MIN;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_ADD:
                state_next = ST_DONE;
            ST_RM_SCAN:
            begin
                if (hit)
                    state_next = ST_RM_RD;
                else if (!pend_valid_reg && !rm_issue)
                    state_next = ST_DONE;
            end
            ST_RM_RD:
                state_next = rm_last ? ST_DONE : ST_RM_WR;
            ST_RM_WR:
                state_next = ST_RM_RD;
            ST_Q_MIN:
                state_next = ST_Q_SCAN;
            ST_Q_SCAN:
            begin
                if (!scan_live && !pend_valid_reg)
                    state_next = ST_Q_WAIT;
            end
            ST_Q_WAIT:
                state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory and count controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ent_addr(rm_idx_reg, slot_reg[SIW-1:0]);
        mem_wtime = time_in_reg;
        mem_wsp   = sp_in_reg;
        mem_raddr = ent_addr(rm_idx_reg, slot_reg[SIW-1:0]);
        cnt_we    = 1'b0;
        cnt_val   = rm_cnt;
        case (state_reg)
            ST_ADD:
            begin
                mem_we    = 1'b1;
                mem_waddr = ent_addr(rm_idx_reg, rm_cnt[SIW-1:0]);
                cnt_we    = 1'b1;
                cnt_val   = rm_cnt + CW'(1);
            end
            ST_RM_RD:
            begin
                mem_raddr = ent_addr(rm_idx_reg, slot_p1[SIW-1:0]);
                cnt_we    = rm_last;
                cnt_val   = rm_cnt - CW'(1);
            end
            ST_RM_WR:
            begin
                // close the gap: move the next entry down one slot
                mem_we    = 1'b1;
                mem_wtime = mem_rtime;
                mem_wsp   = mem_rsp;
            end
            ST_Q_SCAN:
                mem_raddr = ent_addr(room_reg[RIW-1:0], slot_reg[SIW-1:0]);
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cnt_we)
            count_next[rm_idx_reg] = cnt_val;
    end

    // datapath
    always_comb
    begin
        func_next       = func_reg;
        rm_idx_next     = rm_idx_reg;
        rm_ok_next      = rm_ok_reg;
        time_in_next    = time_in_reg;
        sp_in_next      = sp_in_reg;
        hour_next       = hour_reg;
        min_next        = min_reg;
        sec_next        = sec_reg;
        now_next        = now_reg;
        room_next       = room_reg;
        slot_next       = slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_room_next  = pend_room_reg;
        have_any_next   = have_any_reg;
        have_later_next = have_later_reg;
        early_time_next = early_time_reg;
        early_sp_next   = early_sp_reg;
        early_room_next = early_room_reg;
        later_time_next = later_time_reg;
        later_sp_next   = later_sp_reg;
        later_room_next = later_room_reg;
        status_next     = status_reg;
        res_room_next   = res_room_reg;
        res_time_next   = res_time_reg;
        res_sp_next     = res_sp_reg;
        diff_next       = diff_reg;
        q_ok_next       = q_ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next    = func_t'(func);
                    rm_idx_next  = RIW'(room);
                    rm_ok_next   = int'(room) < ROOM_COUNT;
                    time_in_next = event_time;
                    sp_in_next   = setpoint;
                    hour_next    = now_hour;
                    min_next     = now_minute;
                    sec_next     = now_second;
                end
            end
            ST_DISPATCH:
            begin
                q_ok_next       = 1'b0;
                slot_next       = '0;
                room_next       = '0;
                pend_valid_next = 1'b0;
                have_any_next   = 1'b0;
                have_later_next = 1'b0;
                now_next        = TW'(int'(hour_reg) * SEC_PER_HOUR);
                case (func_reg)
                    FUNC_ADD:
                        status_next = (!rm_ok_reg || rm_cnt == SLOTS_C) ? STAT_FULL : STAT_OK;
                    FUNC_REMOVE:
                    begin
                        if (rm_ok_reg && rm_cnt == '0)
                            status_next = STAT_OK;
                        else
                            status_next = STAT_NOT_FOUND;
                    end
                    default:
                        status_next = STAT_OK;
                endcase
            end
            ST_RM_SCAN:
            begin
                pend_valid_next = 1'b0;
                if (hit)
                begin
                    slot_next   = CW'(pend_slot_reg);
                    status_next = STAT_OK;
                end
                else if (rm_issue)
                begin
                    pend_valid_next = 1'b1;
                    pend_slot_next  = slot_reg[SIW-1:0];
                    slot_next       = slot_reg + CW'(1);
                end
            end
            ST_RM_WR:
                slot_next = slot_reg + CW'(1);
            ST_Q_MIN:
                now_next = now_reg + TW'(int'(min_reg) * SEC_PER_MIN) + TW'(sec_reg);
            ST_Q_SCAN:
            begin
                if (pend_valid_reg)
                begin
                    if (!have_any_reg || lt_early)
                    begin
                        have_any_next   = 1'b1;
                        early_time_next = mem_rtime;
                        early_sp_next   = mem_rsp;
                        early_room_next = pend_room_reg;
                    end
                    if (gt_now && (!have_later_reg || lt_later))
                    begin
                        have_later_next = 1'b1;
                        later_time_next = mem_rtime;
                        later_sp_next   = mem_rsp;
                        later_room_next = pend_room_reg;
                    end
                end
                pend_valid_next = 1'b0;
                if (scan_live)
                begin
                    if (scan_issue)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = slot_reg[SIW-1:0];
                        pend_room_next  = room_reg[RIW-1:0];
                        slot_next       = slot_reg + CW'(1);
                    end
                    else
                    begin
                        room_next = room_reg + RCW'(1);
                        slot_next = '0;
                    end
                end
            end
            ST_Q_WAIT:
            begin
                if (!have_any_reg)
                    status_next = STAT_EMPTY;
                else
                begin
                    status_next = STAT_OK;
                    q_ok_next   = 1'b1;
                    if (have_later_reg)
                    begin
                        res_room_next = ROOMW'(later_room_reg);
                        res_time_next = later_time_reg;
                        res_sp_next   = later_sp_reg;
                        diff_next     = $signed({2'b00, later_time_reg})
                                      - $signed({2'b00, now_reg});
                    end
                    else
                    begin
                        res_room_next = ROOMW'(early_room_reg);
                        res_time_next = early_time_reg;
                        res_sp_next   = early_sp_reg;
                        diff_next     = $signed({2'b00, early_time_reg})
                                      - $signed({2'b00, now_reg});
                    end
                end
            end
            default:
            begin
                q_ok_next = q_ok_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < ROOM_COUNT; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        rm_idx_reg     <= rm_idx_next;
        rm_ok_reg      <= rm_ok_next;
        time_in_reg    <= time_in_next;
        sp_in_reg      <= sp_in_next;
        hour_reg       <= hour_next;
        min_reg        <= min_next;
        sec_reg        <= sec_next;
        now_reg        <= now_next;
        room_reg       <= room_next;
        slot_reg       <= slot_next;
        pend_slot_reg  <= pend_slot_next;
        pend_room_reg  <= pend_room_next;
        have_any_reg   <= have_any_next;
        have_later_reg <= have_later_next;
        early_time_reg <= early_time_next;
        early_sp_reg   <= early_sp_next;
        early_room_reg <= early_room_next;
        later_time_reg <= later_time_next;
        later_sp_reg   <= later_sp_next;
        later_room_reg <= later_room_next;
        status_reg     <= status_next;
        res_room_reg   <= res_room_next;
        res_time_reg   <= res_time_next;
        res_sp_reg     <= res_sp_next;
        diff_reg       <= diff_next;
        q_ok_reg       <= q_ok_next;
    end

    assign busy      = state_reg != ST_IDLE;
    assign res_valid = state_reg == ST_DONE;

    always_comb
    begin
        res.status   = status_reg;
        res.room     = q_ok_reg ? res_room_reg : '0;
        res.ev_time  = q_ok_reg ? res_time_reg : '0;
        res.setpoint = q_ok_reg ? res_sp_reg : '0;
        res.wait_s   = q_ok_reg ? wait_val : '0;
    end

endmodule

`default_nettype wire

FILE: design/daily_event_schedule_table.sv
// Top level of the daily event schedule table: sequencer, event storage and
// the registered result stage. Depends on dest_pkg, dest_seq, dest_store.
//
//   channel   handshake           fields
//   request   start / busy        func, room, event_time, setpoint,
//                                 now_hour, now_minute, now_second
//   result    done (1 cycle)      status, next_room, next_time,
//                                 next_setpoint, wait_seconds
//
// Add: dispatch, then the entry write with the count update, then done. No-op,
// add to a full room and remove from an empty room: dispatch, then done.
// Remove: scan of the room at one entry per cycle, then each later entry is
// read and written one slot down to close the gap. Query: the entries are read one
// per cycle, room by room, through the single compare unit and storage read port.
// Reset clears the entry counts at once; no clearing pass. busy is high from
// the cycle after a request until done; results cannot be held off.
`default_nettype none
`include "daily_event_schedule_table_macros.svh"

module daily_event_schedule_table
    import dest_pkg::*;
#(
    parameter int ROOM_COUNT     = ROOM_COUNT_DEF,
    parameter int SLOTS_PER_ROOM = SLOTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [FUNCW-1:0]      func,
    input  wire logic [ROOMW-1:0]      room,
    input  wire logic [TW-1:0]         event_time,
    input  wire logic signed [SPW-1:0] setpoint,
    input  wire logic [HOURW-1:0]      now_hour,
    input  wire logic [MINW-1:0]       now_minute,
    input  wire logic [SECW-1:0]       now_second,
    output logic                       done,
    output logic [STATW-1:0]           status,
    output logic [ROOMW-1:0]           next_room,
    output logic [TW-1:0]              next_time,
    output logic signed [SPW-1:0]      next_setpoint,
    output logic [TW-1:0]              wait_seconds
);

    localparam int DEPTH = ROOM_COUNT * SLOTS_PER_ROOM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  res_valid;
    result_t               res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [TW-1:0]         mem_wtime;
    logic signed [SPW-1:0] mem_wsp;
    logic [AW-1:0]         mem_raddr;
    logic [TW-1:0]         mem_rtime;
    logic signed [SPW-1:0] mem_rsp;

    logic                  done_reg, done_next;
    result_t               out_reg, out_next;

    dest_seq #(
        .ROOM_COUNT     (ROOM_COUNT),
        .SLOTS_PER_ROOM (SLOTS_PER_ROOM)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .room       (room),
        .event_time (event_time),
        .setpoint   (setpoint),
        .now_hour   (now_hour),
        .now_minute (now_minute),
        .now_second (now_second),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wtime  (mem_wtime),
        .mem_wsp    (mem_wsp),
        .mem_raddr  (mem_raddr),
        .mem_rtime  (mem_rtime),
        .mem_rsp    (mem_rsp)
    );

    dest_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wtime (mem_wtime),
        .wsp   (mem_wsp),
        .raddr (mem_raddr),
        .rtime (mem_rtime),
        .rsp   (mem_rsp)
    );

    // pulse done for exactly one cycle; the result fields hold until the next result
    assign done_next = res_valid;
    assign out_next  = res_valid ? res : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done          = done_reg;
    assign status        = out_reg.status;
    assign next_room     = out_reg.room;
    assign next_time     = out_reg.ev_time;
    assign next_setpoint = out_reg.setpoint;
    assign wait_seconds  = out_reg.wait_s;

    `DEST_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `DEST_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `DEST_ASSERT_IMPL(a_empty_zero, clk, rst_n, done && status == STAT_EMPTY, wait_seconds == '0 && next_time == '0)
    `DEST_ASSERT_IMPL(a_full_zero, clk, rst_n, done && status == STAT_FULL, wait_seconds == '0 && next_time == '0)

endmodule

`default_nettype wire
